@@ hw/rtl/bgcrc8_pkg.sv @@
// Package for the bit-granular CRC-8 checker: transaction payload types,
// CRC constants and the byte and tail step functions. No dependencies.
`timescale 1ns / 1ps

package bgcrc8_pkg;

   localparam logic [7:0] CRC_POLY        = 8'h1D;
   localparam logic [7:0] FIRST_BYTE_MASK = 8'h3F;
   localparam int         MIN_BIT_LENGTH  = 14;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first_byte;
      logic [11:0] bit_length;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] checksum;
      logic       length_error;
   } rsp_payload_type;

   function automatic logic [7:0] crc_byte_step(input logic [7:0] value);
      logic [7:0] crc;
      crc = value;
      for (int k = 0; k < 8; k++) begin
         crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
      end
      return crc;
   endfunction

   function automatic logic [7:0] crc_tail_step(input logic [7:0] crc_cur,
                                                input logic [7:0] data,
                                                input logic [2:0] nbits);
      logic [7:0] crc;
      crc = crc_cur;
      for (int k = 0; k < 7; k++) begin
         if (3'(k) < nbits) begin
            crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
            crc[0] = crc[0] ^ data[3'(7 - k)];
         end
      end
      return crc;
   endfunction

endpackage

@@ hw/rtl/bit_granular_crc8_check.sv @@
// Top level of the bit-granular CRC-8 checker (polynomial 0x11D, MSB first).
// Depends on bgcrc8_pkg for payload types and CRC step functions.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_payload_type (byte, first, length)
//   rsp      out        rsp_valid / rsp_ready  rsp_payload_type (checksum, length_error)
//
// One byte transaction per cycle while req_ready is high; the byte or tail CRC step completes in the accepting cycle.
// A result appears in the output register the cycle after the byte that completes the field.
// req_ready drops only while a result is held in the output register and rsp_ready is low.
// Synchronous reset clears the running CRC, byte index, field length and output valid.
`timescale 1ns / 1ps

module bit_granular_crc8_check
   import bgcrc8_pkg::*;
#(
   parameter int MAX_BIT_LENGTH = 4095
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   localparam int LEN_W = $clog2(MAX_BIT_LENGTH + 3);
   localparam int IDX_W = LEN_W - 3;
   localparam int CMP_W = (LEN_W > 12) ? LEN_W : 12;

   logic [7:0]       crc_ff, crc_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [LEN_W-1:0] bits_ff, bits_in;
   logic             active_ff, active_in;
   logic             rsp_valid_ff;
   rsp_payload_type  rsp_ff, rsp_in;

   logic             take, emit;
   logic [CMP_W-1:0] len_ext, len_sat;
   logic [LEN_W-1:0] len_sum;
   logic [IDX_W-1:0] nfull;
   logic [2:0]       tail;
   logic [IDX_W:0]   idx_next;
   logic [7:0]       crc_xor;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign take        = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign len_ext  = CMP_W'(req_payload.bit_length);
   assign len_sat  = (len_ext > CMP_W'(MAX_BIT_LENGTH)) ? CMP_W'(MAX_BIT_LENGTH) : len_ext;
   assign len_sum  = bits_ff + LEN_W'(2);
   assign nfull    = len_sum[LEN_W-1:3];
   assign tail     = len_sum[2:0];
   assign idx_next = {1'b0, idx_ff} + (IDX_W + 1)'(1);
   assign crc_xor  = crc_ff ^ req_payload.data_byte;

   always_comb begin
      crc_in    = crc_ff;
      idx_in    = idx_ff;
      bits_in   = bits_ff;
      active_in = active_ff;
      emit      = 1'b0;
      rsp_in    = '0;
      if (req_payload.first_byte) begin
         bits_in = LEN_W'(len_sat);
         if (len_sat < CMP_W'(MIN_BIT_LENGTH)) begin
            crc_in              = '0;
            idx_in              = '0;
            active_in           = 1'b0;
            emit                = 1'b1;
            rsp_in.length_error = 1'b1;
         end else begin
            crc_in    = crc_byte_step(req_payload.data_byte & FIRST_BYTE_MASK);
            idx_in    = IDX_W'(1);
            active_in = 1'b1;
         end
      end else if (active_ff) begin
         idx_in = idx_next[IDX_W-1:0];
         priority if (idx_next < (IDX_W + 1)'(nfull)) begin
            crc_in = crc_byte_step(crc_xor);
         end else if (idx_next == (IDX_W + 1)'(nfull)) begin
            crc_in = crc_xor;
            if (tail == 3'd0) begin
               active_in       = 1'b0;
               emit            = 1'b1;
               rsp_in.checksum = crc_xor;
            end
         end else begin
            crc_in          = crc_tail_step(crc_ff, req_payload.data_byte, tail);
            active_in       = 1'b0;
            emit            = 1'b1;
            rsp_in.checksum = crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         idx_ff       <= '0;
         bits_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            crc_ff    <= crc_in;
            idx_ff    <= idx_in;
            bits_ff   <= bits_in;
            active_ff <= active_in;
         end
         if (take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   a_error_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.length_error |-> rsp_ff.checksum == 8'h00)
      else $error("flagged result carries a non-zero checksum");

   a_active_index: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> idx_ff != '0 && (IDX_W + 1)'(idx_ff) <= (IDX_W + 1)'(nfull))
      else $error("byte index outside the active field");

   a_active_length: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> bits_ff >= LEN_W'(MIN_BIT_LENGTH))
      else $error("active field shorter than the minimum length");

   a_short_flag: assert property (@(posedge clock) disable iff (reset)
      take && req_payload.first_byte && len_sat < CMP_W'(MIN_BIT_LENGTH)
      |=> rsp_valid_ff && rsp_ff.length_error && !active_ff)
      else $error("short field not flagged");

endmodule

@@ tb/sv/bit_granular_crc8_check_tb.sv @@
// Self-checking testbench for bit_granular_crc8_check: byte transactions in,
// CRC-8 results checked against a cycle-free predictor kept alongside.
// Depends on bgcrc8_pkg and the bit_granular_crc8_check RTL.
`timescale 1ns / 1ps

module bit_granular_crc8_check_tb;
   import bgcrc8_pkg::*;

   localparam int MAX_BIT_LENGTH = 4095;
   localparam int RANDOM_BYTES   = 1750;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_payload_type rsp_payload;

   rsp_payload_type pending_checksums[$];

   logic [7:0]  model_crc;
   int unsigned model_index;
   int unsigned model_bits;
   bit          model_active;

   bit req_idle_on;
   bit rsp_idle_on;
   int rsp_stall_left;
   int failures;
   int bytes_accepted;
   int useful_bytes;
   int fields_checked;
   int flags_seen;

   bit_granular_crc8_check #(.MAX_BIT_LENGTH(MAX_BIT_LENGTH)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] crc8_shift_byte(input logic [7:0] value);
      logic [7:0] crc;
      crc = value;
      repeat (8) crc = {crc[6:0], 1'b0} ^ (crc[7] ? CRC_POLY : 8'h00);
      return crc;
   endfunction

   function automatic logic [7:0] crc8_shift_tail(input logic [7:0] crc_in,
                                                  input logic [7:0] data,
                                                  input int unsigned nbits);
      logic [7:0] crc;
      crc = crc_in;
      for (int k = 0; k < nbits; k++) begin
         crc = {crc[6:0], 1'b0} ^ (crc[7] ? CRC_POLY : 8'h00);
         crc[0] = crc[0] ^ data[7 - k];
      end
      return crc;
   endfunction

   // Advance the predicted field state by one accepted byte; 1 when a result is due.
   function automatic bit crc_field_step(input req_payload_type item,
                                         output rsp_payload_type res);
      int unsigned len;
      int unsigned nfull;
      int unsigned tail;
      res = '0;
      if (item.first_byte) begin
         len = item.bit_length;
         if (len > MAX_BIT_LENGTH) len = MAX_BIT_LENGTH;
         model_bits = len;
         if (len < MIN_BIT_LENGTH) begin
            model_crc = '0;
            model_index = 0;
            model_active = 0;
            res.length_error = 1'b1;
            return 1;
         end
         model_crc = crc8_shift_byte(item.data_byte & FIRST_BYTE_MASK);
         model_index = 1;
         model_active = 1;
         return 0;
      end
      if (!model_active) return 0;
      nfull = (model_bits + 2) / 8;
      tail = (model_bits + 2) % 8;
      if (model_index + 1 < nfull) begin
         model_crc = crc8_shift_byte(model_crc ^ item.data_byte);
         model_index++;
         return 0;
      end
      if (model_index + 1 == nfull) begin
         model_crc = model_crc ^ item.data_byte;
         model_index++;
         if (tail != 0) return 0;
      end else begin
         model_crc = crc8_shift_tail(model_crc, item.data_byte, tail);
         model_index++;
      end
      model_active = 0;
      res.checksum = model_crc;
      return 1;
   endfunction

   function automatic int field_byte_count(input int len);
      if (len < MIN_BIT_LENGTH) return 1;
      return (len + 2) / 8 + (((len + 2) % 8) != 0);
   endfunction

   function automatic req_payload_type make_item(input logic [7:0] data, input bit first,
                                                 input int len);
      req_payload_type item;
      item.data_byte  = data;
      item.first_byte = first;
      item.bit_length = 12'(len);
      return item;
   endfunction

   // Entered and left at a falling edge; valid stays high between back-to-back transactions.
   task automatic send_byte(input req_payload_type item);
      rsp_payload_type res;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_payload = item;
      do @(posedge clock); while (!req_ready);
      bytes_accepted++;
      if (crc_field_step(item, res)) pending_checksums.push_back(res);
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_valid = 1'b0;
      while (pending_checksums.size() != 0) @(negedge clock);
   endtask

   // A negative fill gives random bytes; otherwise every byte takes the fill value.
   task automatic send_field(input int len, input int fill, input int nbytes);
      logic [7:0] data;
      for (int i = 0; i < nbytes; i++) begin
         data = (fill < 0) ? 8'($urandom) : 8'(fill);
         send_byte(make_item(data, i == 0, (i == 0) ? len : int'($urandom_range(0, 4095))));
         useful_bytes++;
      end
   endtask

   task automatic test_short_lengths();
      send_field(0, 8'hFF, 1);
      send_field(MIN_BIT_LENGTH - 1, 8'h00, 1);
      send_field($urandom_range(1, MIN_BIT_LENGTH - 2), -1, 1);
   endtask

   task automatic test_minimum_fields();
      send_field(14, 8'hFF, field_byte_count(14));
      send_field(21, 8'h00, field_byte_count(21));
      send_field(15, 8'hFF, field_byte_count(15));
      send_field(19, -1, field_byte_count(19));
   endtask

   task automatic test_restart_mid_field();
      send_field(30, -1, 2);
      send_field(14, -1, field_byte_count(14));
   endtask

   task automatic test_idle_bytes();
      send_byte(make_item(8'hFF, 1'b0, 12'hFFF));
      send_byte(make_item(8'h00, 1'b0, 0));
      send_field(22, -1, field_byte_count(22) + 2);
      wait_drain();
   endtask

   task automatic test_random_fields();
      int len;
      int pick;
      int long_left;
      long_left = 2;
      while (useful_bytes < RANDOM_BYTES) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            if (long_left > 0 && $urandom_range(0, 40) == 0) begin
               len = (long_left == 2) ? MAX_BIT_LENGTH : int'($urandom_range(2048, 2300));
               long_left--;
            end else if ($urandom_range(0, 4) == 0) begin
               len = $urandom_range(65, 300);
            end else begin
               len = $urandom_range(MIN_BIT_LENGTH, 64);
            end
            send_field(len, -1, field_byte_count(len));
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 3) : 0)
               send_byte(make_item(8'($urandom), 1'b0, $urandom_range(0, 4095)));
         end else if (pick < 88) begin
            send_field($urandom_range(0, MIN_BIT_LENGTH - 1), -1, 1);
         end else if (pick < 95) begin
            len = $urandom_range(MIN_BIT_LENGTH, 120);
            send_field(len, -1, $urandom_range(1, field_byte_count(len) - 1));
         end else begin
            send_byte(make_item(8'($urandom), 1'b0, $urandom_range(0, 4095)));
         end
         if ($urandom_range(0, 24) == 0) wait_drain();
      end
   endtask

   task automatic test_back_to_back();
      int len;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (20) begin
         len = $urandom_range(0, 50);
         send_field(len, -1, field_byte_count(len));
      end
   endtask

   always @(negedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left--;
      end else if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ready = 1'b0;
         rsp_stall_left = $urandom_range(0, 4);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_checksums.size() == 0) begin
            $error("unexpected result: checksum %02h length_error %0b",
                   rsp_payload.checksum, rsp_payload.length_error);
            failures++;
         end else begin
            want = pending_checksums.pop_front();
            if (rsp_payload.checksum !== want.checksum) begin
               $error("checksum mismatch: expected %02h, actual %02h",
                      want.checksum, rsp_payload.checksum);
               failures++;
            end
            if (rsp_payload.length_error !== want.length_error) begin
               $error("length_error mismatch: expected %0b, actual %0b",
                      want.length_error, rsp_payload.length_error);
               failures++;
            end
            if (want.length_error) flags_seen++;
            else fields_checked++;
         end
      end
   end

   initial begin
      #(2_000_000);
      $display("bit_granular_crc8_check test failed");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      model_crc = '0;
      model_index = 0;
      model_bits = 0;
      model_active = 0;
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_short_lengths();
      test_minimum_fields();
      test_restart_mid_field();
      test_idle_bytes();
      test_random_fields();
      test_back_to_back();

      wait_drain();
      repeat (8) @(negedge clock);
      $display("Accepted %0d byte transactions: %0d checksums and %0d short-length flags checked.",
               bytes_accepted, fields_checked, flags_seen);
      if (pending_checksums.size() != 0) begin
         $error("%0d expected results never arrived", pending_checksums.size());
         failures++;
      end
      if (failures == 0) begin
         $display("bit_granular_crc8_check test passed");
      end else begin
         $display("bit_granular_crc8_check test failed");
      end
      $finish;
   end

endmodule

@@ bit_granular_crc8_check.f @@
hw/rtl/bgcrc8_pkg.sv
hw/rtl/bit_granular_crc8_check.sv
tb/sv/bit_granular_crc8_check_tb.sv
